// File: sv/ipdr_pkg.sv
`timescale 1ns / 1ps
// Shared types, request codes, register indexes and CRC terms for the IR receiver.
package ipdr_pkg;

    localparam int FRAME_W   = 40;
    localparam int ENTRY_W   = FRAME_W + 1;
    localparam int DELTA_W   = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 5;

    // Request codes
    localparam logic [1:0] REQ_EDGE  = 2'd0;
    localparam logic [1:0] REQ_POP   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_RECEIVER_ENABLED = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_MIN_NEW     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_MAX_NEW     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_MIN_OLD     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_MAX_OLD     = 3'd4;

    // Data bits per frame
    localparam logic [5:0] BITS_NEW = 6'd40;
    localparam logic [5:0] BITS_OLD = 6'd32;

    // CRC-8 (reflected 0x8C, init 0) contribution of a single message bit
    // followed by m further zero bits: CRC_TERM[m].
    localparam logic [7:0] CRC_TERM [32] = '{
        8'h8C, 8'h46, 8'h23, 8'h9D, 8'hC2, 8'h61, 8'hBC, 8'h5E,
        8'h2F, 8'h9B, 8'hC1, 8'hEC, 8'h76, 8'h3B, 8'h91, 8'hC4,
        8'h62, 8'h31, 8'h94, 8'h4A, 8'h25, 8'h9E, 8'h4F, 8'hAB,
        8'hD9, 8'hE0, 8'h70, 8'h38, 8'h1C, 8'h0E, 8'h07, 8'h8F
    };

    typedef struct packed {
        logic [1:0]         req_type;
        logic [DELTA_W-1:0] delta_ticks;
        logic               level_high;
    } in_t;

    typedef struct packed {
        logic       pop_valid;
        logic       is_legacy;
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
        logic       crc_ok;
        logic       frame_completed;
        logic       frame_dropped;
    } out_t;

    typedef struct packed {
        logic       receiver_enabled;
        logic [4:0] slot_min_new;
        logic [4:0] slot_max_new;
        logic [3:0] slot_min_old;
        logic [3:0] slot_max_old;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               legacy;
        logic [FRAME_W-1:0] bits;
    } enq_t;

    typedef struct packed {
        logic pop_hit;
        logic completed;
        logic dropped;
    } mid_t;

endpackage

// File: sv/ir_pulse_distance_receiver.sv
`timescale 1ns / 1ps
// Top level of the pulse-distance IR frame receiver.
//
// Each transfer on the s_ channel is a line edge, a pop or a clear, and every
// transfer gives exactly one result transfer on the m_ channel. Edges are
// decoded against two frame formats (40-bit new, 32-bit legacy), each with its
// own slot window from the configuration registers; complete frames enter a
// ring queue of QUEUE_DEPTH entries that holds up to QUEUE_DEPTH-1 frames and
// overwrites the oldest when full. A pop returns the oldest frame with its
// format flag and a Dallas CRC-8 check. The block takes one request per clock
// while the result side is not stalled: the decoder, queue indices and the queue
// memory read all settle in the accepting cycle, and the CRC and result
// formatting run from the registered memory read into the output register.
// Write configuration only while no request is in flight; a write to
// receiver_enabled also drops any partial frame.
module ir_pulse_distance_receiver #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  ipdr_pkg::in_t                       s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output ipdr_pkg::out_t                      m_data,

    input  logic                                cfg_we,
    input  logic [ipdr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ipdr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    ipdr_pkg::cfg_t cfg_reg;

    logic s_fire, edge_fire, pop_fire, clear_fire, cfg_clr;
    logic mid_advance;

    logic            mid_valid_reg;
    ipdr_pkg::mid_t  mid_reg;
    logic            m_valid_reg;
    ipdr_pkg::out_t  m_data_reg;

    ipdr_pkg::enq_t                  enq;
    logic                            pop_hit, dropped;
    logic [ipdr_pkg::ENTRY_W-1:0]    rd_entry;
    ipdr_pkg::out_t                  check_result;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.receiver_enabled <= 1'b1;
            cfg_reg.slot_min_new     <= 5'd3;
            cfg_reg.slot_max_new     <= 5'd7;
            cfg_reg.slot_min_old     <= 4'd6;
            cfg_reg.slot_max_old     <= 4'd14;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ipdr_pkg::CFG_RECEIVER_ENABLED: cfg_reg.receiver_enabled <= cfg_wdata[0];
                ipdr_pkg::CFG_SLOT_MIN_NEW:     cfg_reg.slot_min_new     <= cfg_wdata;
                ipdr_pkg::CFG_SLOT_MAX_NEW:     cfg_reg.slot_max_new     <= cfg_wdata;
                ipdr_pkg::CFG_SLOT_MIN_OLD:     cfg_reg.slot_min_old     <= cfg_wdata[3:0];
                ipdr_pkg::CFG_SLOT_MAX_OLD:     cfg_reg.slot_max_old     <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign cfg_clr = cfg_we && (cfg_addr == ipdr_pkg::CFG_RECEIVER_ENABLED);

    // Handshake: advance the middle stage whenever the output slot frees up,
    // and take a new transfer whenever the middle stage moves or is empty.
    assign mid_advance = !m_valid_reg || m_ready;
    assign s_ready     = !mid_valid_reg || mid_advance;
    assign s_fire      = s_valid && s_ready;

    assign edge_fire  = s_fire && (s_data.req_type == ipdr_pkg::REQ_EDGE);
    assign pop_fire   = s_fire && (s_data.req_type == ipdr_pkg::REQ_POP);
    assign clear_fire = s_fire && (s_data.req_type == ipdr_pkg::REQ_CLEAR);

    ipdr_decoder u_decoder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .cfg_clr     (cfg_clr),
        .edge_fire   (edge_fire),
        .clear_fire  (clear_fire),
        .delta_ticks (s_data.delta_ticks),
        .level_high  (s_data.level_high),
        .enq         (enq)
    );

    ipdr_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .enq          (enq),
        .pop_fire     (pop_fire),
        .clear_fire   (clear_fire),
        .pop_hit      (pop_hit),
        .dropped      (dropped),
        .rd_entry_reg (rd_entry)
    );

    ipdr_frame_check u_check (
        .mid    (mid_reg),
        .entry  (rd_entry),
        .result (check_result)
    );

    // Pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) mid_valid_reg <= s_valid;
            if (mid_advance) m_valid_reg <= mid_valid_reg;
        end
    end

    // Pipeline payload: hold while stalled
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            mid_reg.pop_hit   <= pop_hit;
            mid_reg.completed <= enq.valid;
            mid_reg.dropped   <= dropped;
        end
        if (mid_advance && mid_valid_reg) begin
            m_data_reg <= check_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_pop_not_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.pop_valid && m_data.frame_completed))
        else $error("pop result carries an edge flag");

    a_drop_needs_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_dropped) |-> m_data.frame_completed)
        else $error("frame dropped without a completed frame");

    a_crc_needs_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.crc_ok || m_data.is_legacy)) |-> m_data.pop_valid)
        else $error("pop fields set without a popped frame");

    a_legacy_top_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_legacy) |-> (m_data.byte_four == 8'h00))
        else $error("legacy frame with nonzero top byte");

    a_mid_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_valid_reg && !m_valid) |=> m_valid)
        else $error("middle stage did not advance into empty output");
`endif

endmodule

// File: sv/ipdr_decoder.sv
`timescale 1ns / 1ps
// Pulse-distance edge decoder: phase tracking, bit count and frame shift word.
module ipdr_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ipdr_pkg::cfg_t                     cfg,
    input  logic                               cfg_clr,
    input  logic                               edge_fire,
    input  logic                               clear_fire,
    input  logic [ipdr_pkg::DELTA_W-1:0]       delta_ticks,
    input  logic                               level_high,
    output ipdr_pkg::enq_t                     enq
);

    typedef enum logic [6:0] {
        PH_INVALID   = 7'b0000001,
        PH_HDR_NEW   = 7'b0000010,
        PH_MARK_NEW  = 7'b0000100,
        PH_SPACE_NEW = 7'b0001000,
        PH_HDR_OLD   = 7'b0010000,
        PH_MARK_OLD  = 7'b0100000,
        PH_SPACE_OLD = 7'b1000000
    } phase_t;

    phase_t                        phase_reg, phase_next;
    logic [5:0]                    bits_reg, bits_next;
    logic [ipdr_pkg::FRAME_W-1:0]  shift_reg, shift_next;

    logic [8:0] d9;
    logic [8:0] mn1, mx1, mn3, mx3, mn4, mx4, mn8, mx8;
    logic [8:0] mo1, xo1, mo3, xo3, mo8, xo8, mo16, xo16;
    logic       data_mark_new, data_mark_old;

    function automatic logic in_win(input logic [8:0] d, input logic [8:0] lo,
                                    input logic [8:0] hi);
        return (d >= lo) && (d <= hi);
    endfunction

    always_comb begin
        d9   = {1'b0, delta_ticks[7:0]};
        mn1  = 9'(cfg.slot_min_new);
        mx1  = 9'(cfg.slot_max_new);
        mn3  = 9'({cfg.slot_min_new, 1'b0}) + mn1;
        mx3  = 9'({cfg.slot_max_new, 1'b0}) + mx1;
        mn4  = 9'({cfg.slot_min_new, 2'b00});
        mx4  = 9'({cfg.slot_max_new, 2'b00});
        mn8  = 9'({cfg.slot_min_new, 3'b000});
        mx8  = 9'({cfg.slot_max_new, 3'b000});
        mo1  = 9'(cfg.slot_min_old);
        xo1  = 9'(cfg.slot_max_old);
        mo3  = 9'({cfg.slot_min_old, 1'b0}) + mo1;
        xo3  = 9'({cfg.slot_max_old, 1'b0}) + xo1;
        mo8  = 9'({cfg.slot_min_old, 3'b000});
        xo8  = 9'({cfg.slot_max_old, 3'b000});
        mo16 = 9'({cfg.slot_min_old, 4'b0000});
        xo16 = 9'({cfg.slot_max_old, 4'b0000});

        data_mark_new = (phase_reg == PH_MARK_NEW) && in_win(d9, mn1, mx1);
        data_mark_old = (phase_reg == PH_MARK_OLD) && in_win(d9, mo1, xo1);

        phase_next = phase_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        enq        = '0;
        enq.legacy = (phase_reg == PH_MARK_OLD);
        enq.bits   = shift_reg;

        if (cfg_clr || clear_fire) begin
            phase_next = PH_INVALID;
        end else if (edge_fire && cfg.receiver_enabled) begin
            if (delta_ticks[ipdr_pkg::DELTA_W-1:8] != '0) begin
                phase_next = PH_INVALID;
            end else if (level_high) begin
                // Header marks win over data marks in any phase
                if (in_win(d9, mn8, mx8)) begin
                    phase_next = PH_HDR_NEW;
                end else if (in_win(d9, mo16, xo16)) begin
                    phase_next = PH_HDR_OLD;
                end else if (data_mark_new || data_mark_old) begin
                    if (bits_reg == '0) begin
                        phase_next = PH_INVALID;
                        enq.valid  = 1'b1;
                    end else begin
                        phase_next = data_mark_old ? PH_SPACE_OLD : PH_SPACE_NEW;
                        bits_next  = bits_reg - 6'd1;
                    end
                end else begin
                    phase_next = PH_INVALID;
                end
            end else begin
                if ((phase_reg == PH_HDR_NEW) && in_win(d9, mn4, mx4)) begin
                    phase_next = PH_MARK_NEW;
                    shift_next = '0;
                    bits_next  = ipdr_pkg::BITS_NEW;
                end else if ((phase_reg == PH_HDR_OLD) && in_win(d9, mo8, xo8)) begin
                    phase_next = PH_MARK_OLD;
                    shift_next = '0;
                    bits_next  = ipdr_pkg::BITS_OLD;
                end else if ((phase_reg == PH_SPACE_NEW) && in_win(d9, mn3, mx3)) begin
                    phase_next = PH_MARK_NEW;
                    if (bits_reg < ipdr_pkg::BITS_NEW) shift_next[bits_reg] = 1'b1;
                end else if ((phase_reg == PH_SPACE_NEW) && in_win(d9, mn1, mx1)) begin
                    phase_next = PH_MARK_NEW;
                end else if ((phase_reg == PH_SPACE_OLD) && in_win(d9, mo3, xo3)) begin
                    phase_next = PH_MARK_OLD;
                    if (bits_reg < ipdr_pkg::BITS_NEW) shift_next[bits_reg] = 1'b1;
                end else if ((phase_reg == PH_SPACE_OLD) && in_win(d9, mo1, xo1)) begin
                    phase_next = PH_MARK_OLD;
                end else begin
                    phase_next = PH_INVALID;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_INVALID;
            bits_reg  <= '0;
            shift_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
        end
    end

endmodule

// File: sv/ipdr_queue.sv
`timescale 1ns / 1ps
// Frame ring queue: overwrite-oldest storage with registered pop read.
module ipdr_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ipdr_pkg::enq_t                  enq,
    input  logic                            pop_fire,
    input  logic                            clear_fire,
    output logic                            pop_hit,
    output logic                            dropped,
    output logic [ipdr_pkg::ENTRY_W-1:0]    rd_entry_reg
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    logic [ipdr_pkg::ENTRY_W-1:0] mem [QUEUE_DEPTH];

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_inc, rd_inc;

    always_comb begin
        wr_inc = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + IDX_W'(1);
        rd_inc = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + IDX_W'(1);

        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        pop_hit     = 1'b0;
        dropped     = 1'b0;

        if (enq.valid) begin
            wr_idx_next = wr_inc;
            // Full: push the read side past the oldest frame
            if (wr_inc == rd_idx_reg) begin
                rd_idx_next = rd_inc;
                dropped     = 1'b1;
            end
        end else if (pop_fire && (wr_idx_reg != rd_idx_reg)) begin
            pop_hit     = 1'b1;
            rd_idx_next = rd_inc;
        end else if (clear_fire) begin
            rd_idx_next = wr_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (enq.valid) begin
            mem[wr_idx_reg] <= {enq.legacy, enq.bits};
        end
        if (pop_hit) begin
            rd_entry_reg <= mem[rd_idx_reg];
        end
    end

endmodule

// File: sv/ipdr_frame_check.sv
`timescale 1ns / 1ps
// Popped frame check: CRC-8 over the leading bytes and result formatting.
module ipdr_frame_check (
    input  ipdr_pkg::mid_t                  mid,
    input  logic [ipdr_pkg::ENTRY_W-1:0]    entry,
    output ipdr_pkg::out_t                  result
);

    logic [7:0] crc_new, crc_old;
    logic       legacy;

    always_comb begin
        // CRC is linear: XOR the term of every set message bit
        crc_new = '0;
        crc_old = '0;
        for (int p = 0; p < 32; p++) begin
            if (entry[p]) crc_new = crc_new ^ ipdr_pkg::CRC_TERM[31 - p];
        end
        for (int p = 0; p < 24; p++) begin
            if (entry[p]) crc_old = crc_old ^ ipdr_pkg::CRC_TERM[23 - p];
        end

        legacy = entry[ipdr_pkg::FRAME_W];

        result                 = '0;
        result.frame_completed = mid.completed;
        result.frame_dropped   = mid.dropped;
        if (mid.pop_hit) begin
            result.pop_valid  = 1'b1;
            result.is_legacy  = legacy;
            result.byte_zero  = entry[7:0];
            result.byte_one   = entry[15:8];
            result.byte_two   = entry[23:16];
            result.byte_three = entry[31:24];
            result.byte_four  = legacy ? 8'h00 : entry[39:32];
            result.crc_ok     = legacy ? (crc_old == entry[31:24])
                                       : (crc_new == entry[39:32]);
        end
    end

endmodule

// File: tb/ir_pulse_distance_receiver_checker.sv
`timescale 1ns / 1ps
// Checker for the IR receiver: predicts every result and compares it with the m_ channel.
module ir_pulse_distance_receiver_checker #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  ipdr_pkg::in_t                     s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  ipdr_pkg::out_t                    m_data,
    input  logic                              cfg_we,
    input  logic [ipdr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ipdr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                                fail_count,
    output int                                pending
);
    import ipdr_pkg::*;

    localparam logic [7:0]  CRC_POLY  = 8'h8C;
    localparam int          MAX_DELTA = 255;

    typedef enum logic [2:0] {
        DEC_IDLE, DEC_HDR_NEW, DEC_MARK_NEW, DEC_SPACE_NEW,
        DEC_HDR_OLD, DEC_MARK_OLD, DEC_SPACE_OLD
    } dec_phase_t;

    cfg_t               rx_cfg;
    dec_phase_t         dec_phase;
    logic [5:0]         bits_left;
    logic [FRAME_W-1:0] shift_word;
    logic [ENTRY_W-1:0] frame_ring [QUEUE_DEPTH];
    int unsigned        wr_ptr;
    int unsigned        rd_ptr;
    out_t               expected_results [$];
    int                 mismatches;

    function automatic bit in_window(int d, int lo, int hi);
        return d >= lo && d <= hi;
    endfunction

    function automatic int unsigned ring_next(int unsigned i);
        return (i + 1 >= QUEUE_DEPTH) ? 0 : i + 1;
    endfunction

    function automatic logic [7:0] dallas_crc8(logic [FRAME_W-1:0] w, int nbytes);
        logic [7:0] c;
        c = '0;
        for (int k = 0; k < nbytes; k++) begin
            c ^= w[8*k +: 8];
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    function automatic void decode_edge(input logic [DELTA_W-1:0] delta, input logic high,
                                        inout out_t r);
        int d, mn, xn, mo, xo;
        bit legacy;
        d  = delta;
        mn = rx_cfg.slot_min_new;
        xn = rx_cfg.slot_max_new;
        mo = rx_cfg.slot_min_old;
        xo = rx_cfg.slot_max_old;
        if (d > MAX_DELTA) begin
            dec_phase = DEC_IDLE;
            return;
        end
        if (high) begin
            // header marks win over data marks in every phase
            if (in_window(d, mn * 8, xn * 8)) begin
                dec_phase = DEC_HDR_NEW;
            end else if (in_window(d, mo * 16, xo * 16)) begin
                dec_phase = DEC_HDR_OLD;
            end else if ((dec_phase == DEC_MARK_NEW && in_window(d, mn, xn)) ||
                         (dec_phase == DEC_MARK_OLD && in_window(d, mo, xo))) begin
                legacy = (dec_phase == DEC_MARK_OLD);
                if (bits_left == 0) begin
                    dec_phase = DEC_IDLE;
                    frame_ring[wr_ptr] = {legacy, shift_word};
                    wr_ptr = ring_next(wr_ptr);
                    r.frame_completed = 1'b1;
                    if (wr_ptr == rd_ptr) begin
                        rd_ptr = ring_next(rd_ptr);
                        r.frame_dropped = 1'b1;
                    end
                end else begin
                    dec_phase = legacy ? DEC_SPACE_OLD : DEC_SPACE_NEW;
                    bits_left = bits_left - 1'b1;
                end
            end else begin
                dec_phase = DEC_IDLE;
            end
        end else begin
            if (dec_phase == DEC_HDR_NEW && in_window(d, mn * 4, xn * 4)) begin
                dec_phase  = DEC_MARK_NEW;
                shift_word = '0;
                bits_left  = BITS_NEW;
            end else if (dec_phase == DEC_HDR_OLD && in_window(d, mo * 8, xo * 8)) begin
                dec_phase  = DEC_MARK_OLD;
                shift_word = '0;
                bits_left  = BITS_OLD;
            end else if (dec_phase == DEC_SPACE_NEW && in_window(d, mn * 3, xn * 3)) begin
                dec_phase = DEC_MARK_NEW;
                if (bits_left < FRAME_W) shift_word[bits_left] = 1'b1;
            end else if (dec_phase == DEC_SPACE_NEW && in_window(d, mn, xn)) begin
                dec_phase = DEC_MARK_NEW;
            end else if (dec_phase == DEC_SPACE_OLD && in_window(d, mo * 3, xo * 3)) begin
                dec_phase = DEC_MARK_OLD;
                if (bits_left < FRAME_W) shift_word[bits_left] = 1'b1;
            end else if (dec_phase == DEC_SPACE_OLD && in_window(d, mo, xo)) begin
                dec_phase = DEC_MARK_OLD;
            end else begin
                dec_phase = DEC_IDLE;
            end
        end
    endfunction

    function automatic out_t predict_result(in_t req);
        out_t               r;
        logic [ENTRY_W-1:0] e;
        r = '0;
        case (req.req_type)
            REQ_EDGE: begin
                if (rx_cfg.receiver_enabled) decode_edge(req.delta_ticks, req.level_high, r);
            end
            REQ_POP: begin
                if (wr_ptr != rd_ptr) begin
                    e = frame_ring[rd_ptr];
                    rd_ptr = ring_next(rd_ptr);
                    r.pop_valid  = 1'b1;
                    r.is_legacy  = e[FRAME_W];
                    r.byte_zero  = e[7:0];
                    r.byte_one   = e[15:8];
                    r.byte_two   = e[23:16];
                    r.byte_three = e[31:24];
                    if (e[FRAME_W]) begin
                        r.byte_four = '0;
                        r.crc_ok    = dallas_crc8(e[FRAME_W-1:0], 3) == e[31:24];
                    end else begin
                        r.byte_four = e[39:32];
                        r.crc_ok    = dallas_crc8(e[FRAME_W-1:0], 4) == e[39:32];
                    end
                end
            end
            REQ_CLEAR: begin
                rd_ptr    = wr_ptr;
                dec_phase = DEC_IDLE;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int field_differs(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        int   bad;
        if (!aresetn) begin
            rx_cfg     = '{receiver_enabled: 1'b1, slot_min_new: 5'd3, slot_max_new: 5'd7,
                           slot_min_old: 4'd6, slot_max_old: 4'd14};
            dec_phase  = DEC_IDLE;
            bits_left  = '0;
            shift_word = '0;
            foreach (frame_ring[i]) frame_ring[i] = '0;
            wr_ptr     = 0;
            rd_ptr     = 0;
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_RECEIVER_ENABLED: begin
                        rx_cfg.receiver_enabled = cfg_wdata[0];
                        dec_phase = DEC_IDLE;
                    end
                    CFG_SLOT_MIN_NEW: rx_cfg.slot_min_new = cfg_wdata[4:0];
                    CFG_SLOT_MAX_NEW: rx_cfg.slot_max_new = cfg_wdata[4:0];
                    CFG_SLOT_MIN_OLD: rx_cfg.slot_min_old = cfg_wdata[3:0];
                    CFG_SLOT_MAX_OLD: rx_cfg.slot_max_old = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_results.push_back(predict_result(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    bad  = field_differs("pop_valid", want.pop_valid, m_data.pop_valid)
                         + field_differs("is_legacy", want.is_legacy, m_data.is_legacy)
                         + field_differs("byte_zero", want.byte_zero, m_data.byte_zero)
                         + field_differs("byte_one", want.byte_one, m_data.byte_one)
                         + field_differs("byte_two", want.byte_two, m_data.byte_two)
                         + field_differs("byte_three", want.byte_three, m_data.byte_three)
                         + field_differs("byte_four", want.byte_four, m_data.byte_four)
                         + field_differs("crc_ok", want.crc_ok, m_data.crc_ok)
                         + field_differs("frame_completed", want.frame_completed,
                                         m_data.frame_completed)
                         + field_differs("frame_dropped", want.frame_dropped,
                                         m_data.frame_dropped);
                    if (bad != 0) mismatches++;
                end
            end
        end
        pending    <= expected_results.size();
        fail_count <= mismatches;
    end

endmodule

// File: tb/ir_pulse_distance_receiver_tb.sv
`timescale 1ns / 1ps
// Top of the IR receiver testbench: clock, reset, stimulus, result-side stalls and verdict.
module ir_pulse_distance_receiver_tb;
    import ipdr_pkg::*;

    localparam int         QUEUE_DEPTH   = 8;
    localparam int         LIMIT_CYCLES  = 500000;
    localparam int         LONG_HOLD     = 300;
    localparam int         SETTLE_CYCLES = 8;
    // request code the block must ignore
    localparam logic [1:0] REQ_UNUSED    = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_t                   s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_t                  m_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int   fail_count;
    int   pending;
    int   sent_items;
    int   cycle_count;
    int   hold_requests;
    int   holds_done;
    bit   idle_on;
    // stimulus-side copy of the slot windows, used to shape well-formed frames
    cfg_t tx_cfg;

    ir_pulse_distance_receiver #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    ir_pulse_distance_receiver_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: a stuck handshake or a missing result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Result side: short random stalls, long hold-offs on request, and free
    // running stretches. No stalls once idle_on drops for the final part.
    initial begin
        int span;
        m_ready    = 1'b0;
        holds_done = 0;
        @(posedge aclk);
        forever begin
            if (holds_done < hold_requests) begin
                // hold off long enough for the block to back up into its input
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_done++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                span = $urandom_range(1, 14);
                repeat (span) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                span = $urandom_range(1, 24);
                repeat (span) @(posedge aclk);
            end
        end
    end

    // Offer one request and hold it until the transfer. Valid stays high on
    // return so back-to-back requests need no extra edge.
    task automatic send_req(input logic [1:0] kind, input int delta, input bit lvl);
        in_t it;
        int  gap;
        it.req_type    = kind;
        it.delta_ticks = delta[DELTA_W-1:0];
        it.level_high  = lvl;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 14);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic write_config(input bit en, input int mn, input int xn,
                                input int mo, input int xo);
        drain();
        put_reg(CFG_RECEIVER_ENABLED, CFG_DATA_W'(en));
        put_reg(CFG_SLOT_MIN_NEW, CFG_DATA_W'(mn));
        put_reg(CFG_SLOT_MAX_NEW, CFG_DATA_W'(xn));
        put_reg(CFG_SLOT_MIN_OLD, CFG_DATA_W'(mo));
        put_reg(CFG_SLOT_MAX_OLD, CFG_DATA_W'(xo));
        cfg_we <= 1'b0;
        tx_cfg = '{receiver_enabled: en, slot_min_new: mn[4:0], slot_max_new: xn[4:0],
                   slot_min_old: mo[3:0], slot_max_old: xo[3:0]};
    endtask

    // CRC built from the per-bit terms: each set bit contributes the CRC of a
    // one followed by the number of message bits after it.
    function automatic logic [7:0] crc_from_terms(logic [FRAME_W-1:0] w, int nbits);
        logic [7:0] c;
        c = '0;
        for (int j = 0; j < nbits; j++) begin
            if (w[j]) c ^= CRC_TERM[nbits-1-j];
        end
        return c;
    endfunction

    // Send one frame. mode 0 keeps it well formed, 1 corrupts one edge,
    // 2 cuts it short.
    task automatic send_frame(input bit legacy, input int mode);
        in_t                edges [$];
        in_t                it;
        logic [FRAME_W-1:0] word;
        logic [31:0]        lo_rand, hi_rand;
        int                 lo, hi, nbits, hdr_mark, hdr_space, k;
        lo        = legacy ? tx_cfg.slot_min_old : tx_cfg.slot_min_new;
        hi        = legacy ? tx_cfg.slot_max_old : tx_cfg.slot_max_new;
        nbits     = legacy ? 32 : 40;
        hdr_mark  = legacy ? 16 : 8;
        hdr_space = legacy ? 8 : 4;
        lo_rand   = $urandom;
        hi_rand   = $urandom;
        word      = {hi_rand[7:0], lo_rand};
        if (legacy) word[39:32] = '0;
        // mostly a correct CRC byte, sometimes a random one
        if ($urandom_range(0, 3) != 0) begin
            if (legacy) word[31:24] = crc_from_terms(word, 24);
            else        word[39:32] = crc_from_terms(word, 32);
        end
        it.req_type    = REQ_EDGE;
        it.delta_ticks = DELTA_W'($urandom_range(lo * hdr_mark, hi * hdr_mark));
        it.level_high  = 1'b1;
        edges.push_back(it);
        it.delta_ticks = DELTA_W'($urandom_range(lo * hdr_space, hi * hdr_space));
        it.level_high  = 1'b0;
        edges.push_back(it);
        for (int i = nbits - 1; i >= 0; i--) begin
            it.delta_ticks = DELTA_W'($urandom_range(lo, hi));
            it.level_high  = 1'b1;
            edges.push_back(it);
            it.delta_ticks = DELTA_W'(word[i] ? $urandom_range(lo * 3, hi * 3)
                                              : $urandom_range(lo, hi));
            it.level_high  = 1'b0;
            edges.push_back(it);
        end
        // closing mark queues the frame
        it.delta_ticks = DELTA_W'($urandom_range(lo, hi));
        it.level_high  = 1'b1;
        edges.push_back(it);
        if (mode == 1) begin
            k = $urandom_range(0, edges.size() - 1);
            edges[k].delta_ticks = DELTA_W'($urandom_range(0, 300));
            edges[k].level_high  = 1'($urandom_range(0, 1));
        end else if (mode == 2) begin
            k = $urandom_range(1, edges.size() - 1);
            while (edges.size() > k) void'(edges.pop_back());
        end
        foreach (edges[i]) send_req(REQ_EDGE, edges[i].delta_ticks, edges[i].level_high);
    endtask

    // One random burst of activity: mostly frames, the rest noise and requests.
    task automatic run_group();
        int pick, n, d;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            send_frame(1'($urandom_range(0, 1)), 0);
        end else if (pick < 58) begin
            send_frame(1'($urandom_range(0, 1)), $urandom_range(1, 2));
        end else if (pick < 68) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       d = $urandom_range(0, 65535);
                    1:       d = $urandom_range(0, 255);
                    default: d = $urandom_range(0, 31 * 8);
                endcase
                send_req(REQ_EDGE, d, 1'($urandom_range(0, 1)));
            end
        end else if (pick < 84) begin
            n = $urandom_range(1, 3);
            repeat (n) send_req(REQ_POP, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
        end else if (pick < 88) begin
            send_req(REQ_CLEAR, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
        end else if (pick < 93) begin
            send_req(REQ_UNUSED, $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
        end else begin
            send_req(REQ_EDGE, $urandom_range(256, 65535), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input int quota);
        int start;
        start = sent_items;
        while (sent_items - start < quota) run_group();
    endtask

    initial begin
        s_valid       = 1'b0;
        s_data        = '0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        aresetn       = 1'b0;
        idle_on       = 1'b1;
        hold_requests = 0;
        sent_items    = 0;
        tx_cfg        = '{receiver_enabled: 1'b1, slot_min_new: 5'd3, slot_max_new: 5'd7,
                          slot_min_old: 4'd6, slot_max_old: 4'd14};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at reset settings.
        send_req(REQ_POP, 0, 1'b0);             // pop from an empty queue
        send_req(REQ_CLEAR, 65535, 1'b1);
        send_req(REQ_UNUSED, 65535, 1'b1);      // ignored request type
        send_req(REQ_EDGE, 65535, 1'b1);        // delta far out of range
        send_req(REQ_EDGE, 256, 1'b0);          // just past the largest delta
        send_req(REQ_EDGE, 255, 1'b1);
        send_req(REQ_EDGE, 0, 1'b0);
        // header priority: a new-format header mark right after a header space
        send_req(REQ_EDGE, 40, 1'b1);
        send_req(REQ_EDGE, 20, 1'b0);
        send_req(REQ_EDGE, 30, 1'b1);
        // legacy header, one data mark, then a new header mark in a space phase
        send_req(REQ_EDGE, 100, 1'b1);
        send_req(REQ_EDGE, 60, 1'b0);
        send_req(REQ_EDGE, 10, 1'b1);
        send_req(REQ_EDGE, 56, 1'b1);
        send_req(REQ_EDGE, 3, 1'b0);            // not a header space
        send_req(REQ_POP, 1, 1'b1);

        // Disabled receiver: edges are dropped, pops and clears still answer.
        write_config(1'b0, 3, 7, 6, 14);
        send_req(REQ_EDGE, 40, 1'b1);
        send_req(REQ_EDGE, 20, 1'b0);
        send_req(REQ_POP, 0, 1'b0);
        send_req(REQ_CLEAR, 0, 1'b0);

        // Reset settings, random traffic, then keep offering requests while
        // the result side holds off so the block backs up into its input.
        write_config(1'b1, 3, 7, 6, 14);
        run_phase(120);
        hold_requests++;
        run_phase(80);

        // Narrowest new window, widest legacy slot.
        write_config(1'b1, 1, 1, 15, 15);
        run_phase(80);

        // Widest new slot, small legacy window.
        write_config(1'b1, 31, 31, 2, 4);
        run_phase(80);

        // Full-range windows: every high edge of up to 248 ticks looks like a header.
        write_config(1'b1, 0, 31, 0, 15);
        run_phase(30);

        // Empty windows: nothing matches.
        write_config(1'b1, 7, 3, 14, 6);
        run_phase(30);

        write_config(1'b0, 3, 7, 6, 14);
        run_phase(20);

        // Final stretch without any idling on either side.
        write_config(1'b1, 3, 7, 6, 14);
        idle_on = 1'b0;
        run_phase(60);

        drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
